FILE: sv/urfp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// urfp_pkg
// Shared types and constants of the ultrasonic range frame parser.
// ============================================================================
package urfp_pkg;

    // frame header, timeout reset value and timer limit
    localparam logic [7:0]  FRAME_HEADER  = 8'hFF;
    localparam logic [15:0] TIMEOUT_RESET = 16'd300;
    localparam logic [15:0] TIMER_MAX     = 16'hFFFF;

    // input operation codes
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_VALID    = 2'd0,
        ST_CHECKSUM = 2'd1,
        ST_TIMEOUT  = 2'd2
    } status_t;

    // one result item
    typedef struct packed {
        status_t     status;
        logic [15:0] distance_mm;
    } result_t;

endpackage

FILE: sv/urfp_in_if.sv
`timescale 1ns / 1ps
// ============================================================================
// urfp_in_if
// Input channel: one received byte or one millisecond tick per transfer.
// ============================================================================
interface urfp_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

FILE: sv/urfp_out_if.sv
`timescale 1ns / 1ps
// ============================================================================
// urfp_out_if
// Result channel: status and distance per transfer.
// ============================================================================
interface urfp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] distance_mm;

    modport source (output valid, output status, output distance_mm, input ready);
    modport sink   (input valid, input status, input distance_mm, output ready);
endinterface

FILE: sv/urfp_cfg_if.sv
`timescale 1ns / 1ps
// ============================================================================
// urfp_cfg_if
// Configuration write channel carrying the timeout register value.
// ============================================================================
interface urfp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/urfp_parse.sv
`timescale 1ns / 1ps
// ============================================================================
// urfp_parse
// Input register, frame state, timeout timer and result generation.
// ============================================================================
module urfp_parse (
    input  logic              clk,
    input  logic              rst_n,
    urfp_in_if.sink           in,
    urfp_cfg_if.sink          cfg,
    input  logic              res_ready,
    output logic              res_push,
    output urfp_pkg::result_t res
);
    import urfp_pkg::*;

    // frame byte counter codes
    localparam logic [1:0] CNT_IDLE   = 2'd0;
    localparam logic [1:0] CNT_HEADER = 2'd1;
    localparam logic [1:0] CNT_HIGH   = 2'd2;
    localparam logic [1:0] CNT_LOW    = 2'd3;

    logic        vld_reg;
    logic        op_reg;
    logic [7:0]  byte_reg;
    logic [15:0] timeout_reg;
    logic        hdr_reg,     hdr_next;
    logic [1:0]  cnt_reg,     cnt_next;
    logic [7:0]  high_reg,    high_next;
    logic [7:0]  low_reg,     low_next;
    logic [15:0] elapsed_reg, elapsed_next;
    logic        advance;
    logic [15:0] timer_inc;
    logic [7:0]  sum;

    // stage moves on when the result buffer has room
    assign advance  = vld_reg && res_ready;
    assign in.ready = !vld_reg || res_ready;
    assign cfg.ready = 1'b1;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in.ready)
        begin
            vld_reg <= in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in.ready && in.valid)
        begin
            op_reg   <= in.operation;
            byte_reg <= in.rx_byte;
        end
    end

    // timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            timeout_reg <= cfg.data;
        end
    end

    // saturating timer and checksum
    assign timer_inc = (elapsed_reg == TIMER_MAX) ? elapsed_reg : elapsed_reg + 16'd1;
    assign sum       = FRAME_HEADER + high_reg + low_reg;

    // frame parsing
    always_comb
    begin
        hdr_next     = hdr_reg;
        cnt_next     = cnt_reg;
        high_next    = high_reg;
        low_next     = low_reg;
        elapsed_next = elapsed_reg;
        res_push     = 1'b0;
        res.status      = ST_VALID;
        res.distance_mm = '0;
        if (advance)
        begin
            if (op_t'(op_reg) == OP_TICK)
            begin
                elapsed_next = timer_inc;
                if (timer_inc > timeout_reg)
                begin
                    res_push     = 1'b1;
                    res.status   = ST_TIMEOUT;
                    hdr_next     = 1'b0;
                    cnt_next     = CNT_IDLE;
                    high_next    = '0;
                    low_next     = '0;
                    elapsed_next = '0;
                end
            end
            else if (!hdr_reg)
            begin
                if (byte_reg == FRAME_HEADER)
                begin
                    hdr_next = 1'b1;
                    cnt_next = CNT_HEADER;
                end
            end
            else
            begin
                unique case (cnt_reg)
                    CNT_HEADER:
                    begin
                        high_next = byte_reg;
                        cnt_next  = CNT_HIGH;
                    end
                    CNT_HIGH:
                    begin
                        low_next = byte_reg;
                        cnt_next = CNT_LOW;
                    end
                    default:
                    begin
                        res_push = 1'b1;
                        if (sum == byte_reg)
                        begin
                            res.status      = ST_VALID;
                            res.distance_mm = {high_reg, low_reg};
                        end
                        else
                        begin
                            res.status = ST_CHECKSUM;
                        end
                        hdr_next     = 1'b0;
                        cnt_next     = CNT_IDLE;
                        high_next    = '0;
                        low_next     = '0;
                        elapsed_next = '0;
                    end
                endcase
            end
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg     <= 1'b0;
            cnt_reg     <= CNT_IDLE;
            high_reg    <= '0;
            low_reg     <= '0;
            elapsed_reg <= '0;
        end
        else
        begin
            hdr_reg     <= hdr_next;
            cnt_reg     <= cnt_next;
            high_reg    <= high_next;
            low_reg     <= low_next;
            elapsed_reg <= elapsed_next;
        end
    end

    // counter is nonzero exactly while a frame is open
    assert property (@(posedge clk) disable iff (!rst_n)
        hdr_reg == (cnt_reg != CNT_IDLE))
        else $error("frame counter out of step with header flag");

    // every result restarts the timer and the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> (elapsed_reg == '0) && !hdr_reg)
        else $error("state not cleared after result");

    // timeouts come only from ticks, frame results only from bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> ((res.status == ST_TIMEOUT) == (op_t'(op_reg) == OP_TICK)))
        else $error("result kind does not match operation");

    // a distance is reported only with a valid status
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res.status != ST_VALID) |-> (res.distance_mm == '0))
        else $error("distance reported with error status");

endmodule

FILE: sv/urfp_out_buf.sv
`timescale 1ns / 1ps
// ============================================================================
// urfp_out_buf
// Two-entry result buffer that decouples the output handshake from parsing.
// ============================================================================
module urfp_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  urfp_pkg::result_t push_data,
    output logic              room,
    urfp_out_if.source        out
);
    import urfp_pkg::*;

    result_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign room            = (count_reg != 2'd2);
    assign out.valid       = (count_reg != 2'd0);
    assign out.status      = mem_reg[rd_ptr_reg].status;
    assign out.distance_mm = mem_reg[rd_ptr_reg].distance_mm;
    assign pop             = out.valid && out.ready;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: sv/ultrasonic_range_frame_parser.sv
`timescale 1ns / 1ps
// ============================================================================
// ultrasonic_range_frame_parser
// Parses 0xFF-headed four-byte range frames and reports distance or errors.
// ============================================================================
// Each input transfer is a received UART byte or a one millisecond tick. A
// transfer is taken every cycle unless the input register holds an item and
// the two-entry result buffer is full, so throughput is one item per clock.
// An item is parsed in the cycle it leaves the input register, which needs
// room in the result buffer. Its result, if any, is written to the buffer
// at the end of that cycle and offered on the output channel from the next
// cycle. A frame yields a distance in mm or a checksum error. A tick count
// above timeout_reg yields a timeout and drops any partial frame. The
// timeout register is written through cfg at any time the block is idle
// and resets to 300.
module ultrasonic_range_frame_parser (
    input  logic        clk,
    input  logic        rst_n,
    urfp_in_if.sink     in,
    urfp_out_if.source  out,
    urfp_cfg_if.sink    cfg
);
    import urfp_pkg::*;

    logic    res_ready;
    logic    res_push;
    result_t res;

    // parse stage
    urfp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .in        (in),
        .cfg       (cfg),
        .res_ready (res_ready),
        .res_push  (res_push),
        .res       (res)
    );

    // result buffer
    urfp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res),
        .room      (res_ready),
        .out       (out)
    );

endmodule
